/* hdl/host_to_device_range_map_core_assert.svh */
// Assertion macros shared by the range map RTL.
// Included by the top level; relies on no other file.
`ifndef HOST_TO_DEVICE_RANGE_MAP_CORE_ASSERT_SVH
`define HOST_TO_DEVICE_RANGE_MAP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HRM_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define HRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HRM_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define HRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/hrm_pkg.sv */
// Shared types and codes of the host-to-device range map.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package hrm_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK            = 3'd0,
		STS_FULL          = 3'd1,
		STS_MISMATCH      = 3'd2,
		STS_NOT_FOUND     = 3'd3,
		STS_SIZE_MISMATCH = 3'd4,
		STS_SATURATED     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear_wr;
		logic rd_en;
		logic eval;
		logic calc;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic noop;
		logic out_busy;
	} dp_stat_t;

endpackage

/* hdl/hrm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module hrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/hrm_ctrl.sv */
// Controller of the range map: clearing pass, table scan and result hand-off.
// Depends on hrm_pkg.
`timescale 1ns / 1ps
module hrm_ctrl #(
	parameter int ENTRIES = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_ready,
	input  hrm_pkg::dp_stat_t  stat,
	output hrm_pkg::ctrl_cmd_t cmd,
	output logic [IW-1:0]      idx
);
	import hrm_pkg::*;

	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic          eval_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			eval_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			eval_s1 <= (state_q == ST_SCAN);
			if (cmd.capture || (state_q == ST_CLEAR && cnt_q == LAST)) begin
				cnt_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (cnt_q == LAST) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.noop) state_d = ST_DONE;
				else if (cnt_q == LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_CALC;
			ST_CALC:  state_d = ST_DONE;
			ST_DONE:  if (!stat.out_busy || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.clear_wr = (state_q == ST_CLEAR);
		cmd.rd_en    = (state_q == ST_SCAN);
		cmd.eval     = eval_s1;
		cmd.calc     = (state_q == ST_CALC);
		cmd.commit   = (state_q == ST_DONE) && (!stat.out_busy || out_ready);
	end

	assign idx = cnt_q;

endmodule

/* hdl/hrm_dp.sv */
// Datapath of the range map: entry RAM, scan trackers, update and result register.
// Depends on hrm_pkg and hrm_ram.
`timescale 1ns / 1ps
module hrm_dp #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 48,
	parameter int REF_BITS  = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hrm_pkg::ctrl_cmd_t   cmd,
	input  logic [IW-1:0]        idx,
	output hrm_pkg::dp_stat_t    stat,
	input  logic [1:0]           in_cmd,
	input  logic [ADDR_BITS-1:0] in_host_addr,
	input  logic [ADDR_BITS-1:0] in_dev_addr,
	input  logic [ADDR_BITS-1:0] in_length,
	input  logic                 in_must_be_present,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [ADDR_BITS-1:0] out_device_addr,
	output logic                 out_absent_error,
	output hrm_pkg::status_t     out_status
);
	import hrm_pkg::*;

	localparam int A = ADDR_BITS;
	localparam int R = REF_BITS;
	// Entry word from the top: valid, host start, size, device start, count.
	localparam int W = 1 + 3 * A + R;
	localparam logic [R-1:0] REF_MAX = {R{1'b1}};

	// Captured command.
	cmd_t          cmd_q;
	logic [A-1:0]  ha_q, da_q, len_q;
	logic          need_q, noop_q;

	// Scan trackers.
	logic [IW-1:0] idx_s1;
	logic          best_v_q, match_v_q, free_v_q;
	logic [A-1:0]  best_hs_q, best_sz_q, best_ds_q;
	logic [IW-1:0] match_idx_q, free_idx_q;
	logic [A-1:0]  match_sz_q, match_ds_q;
	logic [R-1:0]  match_rc_q;
	logic [A-1:0]  diff_q;

	// Result register.
	logic          out_valid_q;
	logic [A-1:0]  out_dev_q;
	logic          out_err_q;
	status_t       out_st_q;

	logic [W-1:0]  rd_word;
	logic          e_v;
	logic [A-1:0]  e_hs, e_sz, e_ds;
	logic [R-1:0]  e_rc;

	logic          upd_we;
	logic [IW-1:0] upd_addr;
	logic [W-1:0]  upd_word;
	logic [A-1:0]  res_dev;
	logic          res_err;
	status_t       res_st;
	logic [R-1:0]  rc_dec;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [W-1:0]  ram_wdata;

	assign ram_we    = cmd.clear_wr || (cmd.commit && upd_we);
	assign ram_waddr = cmd.clear_wr ? idx : upd_addr;
	assign ram_wdata = cmd.clear_wr ? '0 : upd_word;

	hrm_ram #(
		.WIDTH(W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(idx),
		.rdata(rd_word)
	);

	assign e_rc = rd_word[R-1:0];
	assign e_ds = rd_word[R+A-1:R];
	assign e_sz = rd_word[R+2*A-1:R+A];
	assign e_hs = rd_word[R+3*A-1:R+2*A];
	assign e_v  = rd_word[W-1];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= cmd_t'(in_cmd);
			ha_q   <= in_host_addr;
			da_q   <= in_dev_addr;
			len_q  <= in_length;
			need_q <= in_must_be_present;
			noop_q <= (in_host_addr == '0) ||
				!(in_cmd == CMD_LOOKUP || in_cmd == CMD_INSERT || in_cmd == CMD_REMOVE);
		end
		if (cmd.rd_en) begin
			idx_s1 <= idx;
		end
		if (cmd.eval) begin
			// Greatest valid start not above the address.
			if (e_v && e_hs <= ha_q && (!best_v_q || e_hs > best_hs_q)) begin
				best_hs_q <= e_hs;
				best_sz_q <= e_sz;
				best_ds_q <= e_ds;
			end
			if (e_v && e_hs == ha_q && !match_v_q) begin
				match_idx_q <= idx_s1;
				match_sz_q  <= e_sz;
				match_ds_q  <= e_ds;
				match_rc_q  <= e_rc;
			end
			if (!e_v && !free_v_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (cmd.calc) begin
			diff_q <= ha_q - best_hs_q;
		end
		if (cmd.commit) begin
			out_dev_q <= res_dev;
			out_err_q <= res_err;
			out_st_q  <= res_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_v_q    <= 1'b0;
			match_v_q   <= 1'b0;
			free_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				best_v_q  <= 1'b0;
				match_v_q <= 1'b0;
				free_v_q  <= 1'b0;
			end else if (cmd.eval) begin
				if (e_v && e_hs <= ha_q) best_v_q <= 1'b1;
				if (e_v && e_hs == ha_q) match_v_q <= 1'b1;
				if (!e_v) free_v_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rc_dec = (match_rc_q != '0) ? match_rc_q - R'(1) : '0;

	always_comb begin
		res_dev  = '0;
		res_err  = 1'b0;
		res_st   = STS_OK;
		upd_we   = 1'b0;
		upd_addr = match_idx_q;
		upd_word = {1'b1, ha_q, match_sz_q, match_ds_q, match_rc_q};
		if (!noop_q) begin
			unique case (cmd_q)
				CMD_LOOKUP: begin
					if (best_v_q && diff_q < best_sz_q) begin
						res_dev = best_ds_q + diff_q;
					end else begin
						res_err = need_q;
					end
				end
				CMD_INSERT: begin
					if (match_v_q) begin
						if (match_sz_q != len_q || match_ds_q != da_q) begin
							res_st = STS_MISMATCH;
						end else if (match_rc_q == REF_MAX) begin
							res_st = STS_SATURATED;
						end else begin
							upd_we   = 1'b1;
							upd_word = {1'b1, ha_q, match_sz_q, match_ds_q,
								match_rc_q + R'(1)};
						end
					end else if (free_v_q) begin
						upd_we   = 1'b1;
						upd_addr = free_idx_q;
						upd_word = {1'b1, ha_q, len_q, da_q, R'(1)};
					end else begin
						res_st = STS_FULL;
					end
				end
				CMD_REMOVE: begin
					if (!match_v_q) begin
						res_st = STS_NOT_FOUND;
					end else if (match_sz_q != len_q) begin
						res_st = STS_SIZE_MISMATCH;
					end else begin
						// The entry is freed once its last reference goes.
						upd_we   = 1'b1;
						upd_word = {(rc_dec != '0), ha_q, match_sz_q, match_ds_q, rc_dec};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.noop     = noop_q;
	assign stat.out_busy = out_valid_q;

	assign out_valid        = out_valid_q;
	assign out_device_addr  = out_dev_q;
	assign out_absent_error = out_err_q;
	assign out_status       = out_st_q;

endmodule

/* hdl/host_to_device_range_map_core.sv */
// Host-to-device range map: input stream of lookup, insert and remove words, one
// result word per command. Top level; depends on hrm_pkg, hrm_ctrl, hrm_dp.
//
// The slave channel carries one command word. s_tdata holds host_addr,
// dev_addr and length; s_tuser holds cmd and must_be_present. The master
// channel returns one result word per command: device_addr in m_tdata,
// absent_error and status in m_tuser.
// Each command reads every table entry once through the single read port of
// the entry RAM, one entry per cycle. One command is in flight at a time, so the
// next word is not taken before the previous command has finished; a command
// with host address zero or an unused code skips the scan.
// The result sits in an output register, so a new command is taken while the
// previous result still waits; if the receiver stalls, the next command holds
// at its final step until that register frees up.
// After reset a clearing pass writes every entry invalid, one per cycle;
// s_tready stays low until it completes.
`timescale 1ns / 1ps
module host_to_device_range_map_core #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 48,
	parameter int REF_BITS  = 16,
	localparam int IN_DW  = ((3 * ADDR_BITS + 7) / 8) * 8,
	localparam int OUT_DW = ((ADDR_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,  // host_addr, dev_addr, length, zero pad
	input  logic [2:0]        s_tuser,  // cmd[1:0], must_be_present
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,  // device_addr, zero pad
	output logic [3:0]        m_tuser   // absent_error, status[2:0]
);
	import hrm_pkg::*;
	`include "host_to_device_range_map_core_assert.svh"

	localparam int A  = ADDR_BITS;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	ctrl_cmd_t     ctl_cmd;
	dp_stat_t      dp_stat;
	logic [IW-1:0] idx;
	logic [A-1:0]  res_dev;
	logic          res_err;
	status_t       res_st;

	hrm_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_ready(m_tready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd),
		.idx      (idx)
	);

	hrm_dp #(
		.ENTRIES  (ENTRIES),
		.ADDR_BITS(ADDR_BITS),
		.REF_BITS (REF_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (ctl_cmd),
		.idx               (idx),
		.stat              (dp_stat),
		.in_cmd            (s_tuser[1:0]),
		.in_host_addr      (s_tdata[A-1:0]),
		.in_dev_addr       (s_tdata[2*A-1:A]),
		.in_length         (s_tdata[3*A-1:2*A]),
		.in_must_be_present(s_tuser[2]),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.out_device_addr   (res_dev),
		.out_absent_error  (res_err),
		.out_status        (res_st)
	);

	assign m_tdata = OUT_DW'(res_dev);
	assign m_tuser = {res_st, res_err};

	`HRM_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"second command accepted while one is in flight")
	`HRM_ASSERT_ALWAYS(a_no_capture_on_commit, clk, arst_n,
		!(ctl_cmd.capture && ctl_cmd.commit), "capture and commit in the same cycle")
	`HRM_ASSERT_ALWAYS(a_clear_blocks_input, clk, arst_n,
		!(ctl_cmd.clear_wr && s_tready), "input ready during the clearing pass")
	`HRM_ASSERT_NEXT(a_commit_shows_result, clk, arst_n, ctl_cmd.commit, m_tvalid,
		"committed result not presented")

endmodule
